>>> hw/rtl/indexed_priority_heap_core_macros.svh
// Assertion macros for the indexed priority heap core.
`ifndef INDEXED_PRIORITY_HEAP_CORE_MACROS_SVH
`define INDEXED_PRIORITY_HEAP_CORE_MACROS_SVH

// Checked property, disabled while reset is asserted.
`define IPH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked property that also holds during reset.
`define IPH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/iph_pkg.sv
// Types, constants and the rank compare for the indexed priority heap.
package iph_pkg;

  localparam int unsigned MAX_KEYS   = 256;
  localparam int unsigned STAMP_BITS = 32;
  localparam int unsigned KEY_W      = 8;
  localparam int unsigned KEY_SPACE  = 1 << KEY_W;
  localparam int unsigned LEVEL_W    = 7;
  localparam int unsigned SLOT_W     = $clog2(MAX_KEYS);
  localparam int unsigned CNT_W      = SLOT_W + 1;
  localparam int unsigned CHILD_W    = SLOT_W + 2;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(100);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_RAISE  = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [KEY_W-1:0]   cat_id;
    logic [LEVEL_W-1:0] amount;
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0] top_key;
    logic             heap_empty;
  } result_t;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [LEVEL_W-1:0]    level;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

  // Higher level wins; equal levels go to the smaller stamp.
  function automatic logic ranks_above(entry_t a, entry_t b);
    logic r;
    if (a.level != b.level) begin
      r = (a.level > b.level);
    end else begin
      r = (a.stamp < b.stamp);
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/indexed_priority_heap_core.sv
// Indexed binary max-heap with per-key slot map, one command word at a time.
//
// Usage: drive cmd_i and pulse start_i while busy_o is low; the word is taken
// at that edge and busy_o rises on the next cycle. Commands: insert, raise
// level, remove, query top. Only a query returns a word: result_valid_o is
// high for exactly one cycle with result_o, and the receiver cannot stall it.
// Ignored commands (absent key, duplicate insert, full heap) end quietly
// in decode and return to idle.
//
// Sequencing: a query's result_valid_o is high in the cycle busy_o falls. Insert
// goes from decode straight to the climb; raise and remove first load the entry
// to move. Each heap level climbed costs a registered read and a compare/write
// step; remove may climb and then sifts down, each level a read and a compare.
// The pace is set by the single heap memory; a new word is taken only once
// busy_o is low again.
//
// Reset clears the fill count, the stamp counter and the 256 key-present
// bits at once; the heap and slot memories are not cleared and need no pass.
module indexed_priority_heap_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  iph_pkg::cmd_t   cmd_i,
  output logic            busy_o,
  output logic            result_valid_o,
  output iph_pkg::result_t result_o
);
  import iph_pkg::*;

  `include "indexed_priority_heap_core_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_LOAD, ST_UP_RD, ST_UP_CMP, ST_DN_RD, ST_DN_CMP
  } state_e;

  state_e                state_q;
  cmd_t                  item_q;
  entry_t                cur_q;
  logic [SLOT_W-1:0]     idx_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [STAMP_BITS-1:0] stamp_q;
  logic [KEY_SPACE-1:0]  present_q;
  logic                  down_q;
  logic                  result_valid_q;
  result_t               result_q;

  // heap memory: one write port, two registered read ports
  entry_t heap_mem [MAX_KEYS];
  entry_t ha_rd, hb_rd;
  logic [SLOT_W-1:0] ha_addr, hb_addr, hw_addr;
  entry_t hw_data;
  logic hw_en;

  // slot map memory
  logic [SLOT_W-1:0] pos_mem [KEY_SPACE];
  logic [SLOT_W-1:0] pos_rd;
  logic [KEY_W-1:0]  p_raddr, pw_addr;
  logic [SLOT_W-1:0] pw_data;
  logic              pw_en;

  always_ff @(posedge clk_i) begin
    if (hw_en) begin
      heap_mem[hw_addr] <= hw_data;
    end
    ha_rd <= heap_mem[ha_addr];
    hb_rd <= heap_mem[hb_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pw_en) begin
      pos_mem[pw_addr] <= pw_data;
    end
    pos_rd <= pos_mem[p_raddr];
  end

  logic [SLOT_W-1:0]  last_slot, parent;
  logic [CHILD_W-1:0] lchild, rchild;
  logic               l_ok, r_ok, up_wins, pick_l, pick_r;
  entry_t             best_ent;
  logic [LEVEL_W:0]   raised;
  logic [LEVEL_W-1:0] raised_sat, ins_level;

  assign last_slot = SLOT_W'(cnt_q - CNT_W'(1));
  assign parent    = SLOT_W'((idx_q - SLOT_W'(1)) >> 1);
  assign lchild    = {1'b0, idx_q, 1'b1};
  assign rchild    = lchild + CHILD_W'(1);
  assign l_ok      = lchild < CHILD_W'(cnt_q);
  assign r_ok      = rchild < CHILD_W'(cnt_q);
  assign up_wins   = ranks_above(cur_q, ha_rd);
  assign raised    = {1'b0, ha_rd.level} + {1'b0, item_q.amount};
  assign raised_sat = (raised > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : raised[LEVEL_W-1:0];
  assign ins_level = (item_q.amount > LEVEL_MAX) ? LEVEL_MAX : item_q.amount;

  always_comb begin
    pick_l   = 1'b0;
    pick_r   = 1'b0;
    best_ent = cur_q;
    if (l_ok && ranks_above(ha_rd, cur_q)) begin
      pick_l   = 1'b1;
      best_ent = ha_rd;
    end
    if (r_ok && ranks_above(hb_rd, best_ent)) begin
      pick_l = 1'b0;
      pick_r = 1'b1;
    end
  end

  always_comb begin
    ha_addr = '0;
    hb_addr = '0;
    hw_en   = 1'b0;
    hw_addr = idx_q;
    hw_data = cur_q;
    pw_en   = 1'b0;
    pw_addr = cur_q.key;
    pw_data = idx_q;
    p_raddr = cmd_i.cat_id;
    unique case (state_q)
      ST_IDLE: ;
      ST_DECODE: begin
        ha_addr = (item_q.cmd == CMD_RAISE) ? pos_rd : last_slot;
      end
      ST_LOAD: ;
      ST_UP_RD: begin
        ha_addr = parent;
        if (idx_q == '0 && !down_q) begin
          hw_en = 1'b1;
          pw_en = 1'b1;
        end
      end
      ST_UP_CMP: begin
        if (up_wins) begin
          hw_en   = 1'b1;
          hw_data = ha_rd;
          pw_en   = 1'b1;
          pw_addr = ha_rd.key;
        end else if (!down_q) begin
          hw_en = 1'b1;
          pw_en = 1'b1;
        end
      end
      ST_DN_RD: begin
        ha_addr = lchild[SLOT_W-1:0];
        hb_addr = rchild[SLOT_W-1:0];
      end
      ST_DN_CMP: begin
        hw_en = 1'b1;
        pw_en = 1'b1;
        if (pick_l) begin
          hw_data = ha_rd;
          pw_addr = ha_rd.key;
        end else if (pick_r) begin
          hw_data = hb_rd;
          pw_addr = hb_rd.key;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      stamp_q        <= '0;
      present_q      <= '0;
      down_q         <= 1'b0;
      result_valid_q <= 1'b0;
      result_q       <= '0;
      item_q         <= '0;
      idx_q          <= '0;
      cur_q          <= '0;
    end else begin
      result_valid_q <= (state_q == ST_DECODE) && (item_q.cmd == CMD_QUERY);
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            item_q  <= cmd_i;
            state_q <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          unique case (item_q.cmd)
            CMD_INSERT: begin
              if (!present_q[item_q.cat_id] && cnt_q != CNT_W'(MAX_KEYS)) begin
                cur_q   <= '{key: item_q.cat_id, level: ins_level, stamp: stamp_q};
                stamp_q <= stamp_q + STAMP_BITS'(1);
                idx_q   <= SLOT_W'(cnt_q);
                cnt_q   <= cnt_q + CNT_W'(1);
                present_q[item_q.cat_id] <= 1'b1;
                down_q  <= 1'b0;
                state_q <= ST_UP_RD;
              end else begin
                state_q <= ST_IDLE;
              end
            end
            CMD_RAISE: begin
              if (present_q[item_q.cat_id]) begin
                idx_q   <= pos_rd;
                down_q  <= 1'b0;
                state_q <= ST_LOAD;
              end else begin
                state_q <= ST_IDLE;
              end
            end
            CMD_REMOVE: begin
              if (present_q[item_q.cat_id]) begin
                present_q[item_q.cat_id] <= 1'b0;
                cnt_q   <= cnt_q - CNT_W'(1);
                idx_q   <= pos_rd;
                down_q  <= 1'b1;
                state_q <= (pos_rd != last_slot) ? ST_LOAD : ST_IDLE;
              end else begin
                state_q <= ST_IDLE;
              end
            end
            CMD_QUERY: begin
              result_q <= '{top_key: (cnt_q == '0) ? '0 : ha_rd.key,
                            heap_empty: (cnt_q == '0)};
              state_q  <= ST_IDLE;
            end
            default: state_q <= ST_IDLE;
          endcase
        end
        ST_LOAD: begin
          cur_q <= '{key: ha_rd.key,
                     level: (item_q.cmd == CMD_RAISE) ? raised_sat : ha_rd.level,
                     stamp: ha_rd.stamp};
          state_q <= ST_UP_RD;
        end
        ST_UP_RD: begin
          if (idx_q == '0) begin
            state_q <= down_q ? ST_DN_RD : ST_IDLE;
          end else begin
            state_q <= ST_UP_CMP;
          end
        end
        ST_UP_CMP: begin
          if (up_wins) begin
            idx_q   <= parent;
            state_q <= ST_UP_RD;
          end else begin
            state_q <= down_q ? ST_DN_RD : ST_IDLE;
          end
        end
        ST_DN_RD: state_q <= ST_DN_CMP;
        ST_DN_CMP: begin
          if (pick_l) begin
            idx_q   <= lchild[SLOT_W-1:0];
            state_q <= ST_DN_RD;
          end else if (pick_r) begin
            idx_q   <= rchild[SLOT_W-1:0];
            state_q <= ST_DN_RD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  `IPH_ASSERT(a_result_from_query, result_valid_o |-> $past(state_q == ST_DECODE && item_q.cmd == CMD_QUERY), "result word without a query")
  `IPH_ASSERT(a_take_sets_busy, start_i && !busy_o |=> busy_o, "accepted word did not raise busy")
  `IPH_ASSERT_ALWAYS(a_count_bound, cnt_q <= CNT_W'(MAX_KEYS), "fill count above capacity")
  `IPH_ASSERT(a_empty_key_zero, result_valid_o && result_o.heap_empty |-> result_o.top_key == '0, "empty result with nonzero key")

endmodule
